[rtl/core/kmst_pkg.sv]
package kmst_pkg;

  // Fixed field widths
  localparam int VW      = 4;
  localparam int WW      = 15;
  localparam int CW      = 5;
  localparam int RANK_W  = 3;
  localparam int NV      = 2 ** VW;

  localparam logic [WW-1:0]     NO_EDGE_W = 15'h7FFF;
  localparam logic [RANK_W-1:0] RANK_MAX  = 3'd7;
  localparam logic [CW-1:0]     VC_RESET  = 5'd16;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int MAX_EDGES_DEF    = 256;

  typedef struct packed {
    logic [VW-1:0] src;
    logic [VW-1:0] dst;
    logic [WW-1:0] w;
  } kmst_edge_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SORT_INIT,
    ST_BUILD,
    ST_HELD,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_EXTRACT,
    ST_SWAP,
    ST_SCAN,
    ST_SCAN_RD,
    ST_FIND_A,
    ST_FIND_B,
    ST_FINISH
  } kmst_state_e;

  typedef struct packed {
    logic              clear;
    logic              find_go;
    logic [VW-1:0]     find_v;
    logic              join_go;
    logic [VW-1:0]     ja;
    logic [VW-1:0]     jb;
    logic [RANK_W-1:0] rka;
    logic [RANK_W-1:0] rkb;
  } uf_req_t;

  typedef struct packed {
    logic              done;
    logic [VW-1:0]     root;
    logic [RANK_W-1:0] rank;
  } uf_rsp_t;

endpackage

[rtl/core/kmst_edge_ram.sv]
module kmst_edge_ram import kmst_pkg::*; #(
  parameter int DEPTH = MAX_EDGES_DEF + 1,
  parameter int AW    = $clog2(MAX_EDGES_DEF + 1)
) (
  input  logic       clk_i,
  input  logic       we_i,
  input  logic [AW-1:0] waddr_i,
  input  kmst_edge_t wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output kmst_edge_t rdata_a_o,
  output kmst_edge_t rdata_b_o
);

  kmst_edge_t mem [DEPTH];

  // One write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

[rtl/core/kmst_uf.sv]
module kmst_uf import kmst_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  uf_req_t req_i,
  output uf_rsp_t rsp_o
);

  logic [VW-1:0]     par_q [NV];
  logic [RANK_W-1:0] rnk_q [NV];
  logic [NV-1:0]     pv_q, rv_q;
  logic              busy_q;
  logic [VW-1:0]     x_q;
  logic [VW-1:0]     p;

  // Entries not yet written read as their own index and rank zero
  assign p           = pv_q[x_q] ? par_q[x_q] : x_q;
  assign rsp_o.done  = busy_q && (p == x_q);
  assign rsp_o.root  = x_q;
  assign rsp_o.rank  = rv_q[x_q] ? rnk_q[x_q] : '0;

  // Walk one parent link per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      x_q    <= '0;
    end else if (req_i.find_go) begin
      busy_q <= 1'b1;
      x_q    <= req_i.find_v;
    end else if (busy_q) begin
      if (p == x_q) begin
        busy_q <= 1'b0;
      end else begin
        x_q <= p;
      end
    end
  end

  // Valid bits: clear whole forest at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
      rv_q <= '0;
    end else if (req_i.clear) begin
      pv_q <= '0;
      rv_q <= '0;
    end else if (req_i.join_go) begin
      if (req_i.rka > req_i.rkb) begin
        pv_q[req_i.jb] <= 1'b1;
      end else begin
        pv_q[req_i.ja] <= 1'b1;
        if (req_i.rka == req_i.rkb && req_i.rkb < RANK_MAX) begin
          rv_q[req_i.jb] <= 1'b1;
        end
      end
    end
  end

  // Union by rank
  always_ff @(posedge clk_i) begin
    if (req_i.join_go && !req_i.clear) begin
      if (req_i.rka > req_i.rkb) begin
        par_q[req_i.jb] <= req_i.ja;
      end else begin
        par_q[req_i.ja] <= req_i.jb;
        if (req_i.rka == req_i.rkb && req_i.rkb < RANK_MAX) begin
          rnk_q[req_i.jb] <= req_i.rkb + 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/kruskal_minimum_spanning_tree.sv]
// Channel   Direction  Handshake                 Payload
// config    in         cfg_we_i                  cfg_wdata_i (vertex count)
// entry     in         start_i high, busy_o low  row_vertex_i col_vertex_i weight_i
//                                                last_entry_i
// result    out        res_strobe_o (one cycle)  edge_from_o edge_to_o edge_weight_o
//                                                edge_valid_o last_result_o
//
// Entries load at one per cycle while busy_o is low. After the last entry
// busy_o stays high while a heapsort runs on the edge RAM and then a
// union-find scan runs over the sorted edges; the single RAM and the one
// find unit set how long this takes.
// Reset clears the edge count and the forest; the edge RAM needs no clearing.
// Results are strobed for one cycle and cannot be stalled.
module kruskal_minimum_spanning_tree import kmst_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [CW-1:0] cfg_wdata_i,
  input  logic          start_i,
  output logic          busy_o,
  input  logic [VW-1:0] row_vertex_i,
  input  logic [VW-1:0] col_vertex_i,
  input  logic [WW-1:0] weight_i,
  input  logic          last_entry_i,
  output logic          res_strobe_o,
  output logic [VW-1:0] edge_from_o,
  output logic [VW-1:0] edge_to_o,
  output logic [WW-1:0] edge_weight_o,
  output logic          edge_valid_o,
  output logic          last_result_o
);

  localparam int AW    = $clog2(MAX_EDGES + 1);
  localparam int DEPTH = MAX_EDGES + 1;
  localparam int VLIM  = (MAX_VERTICES < NV) ? MAX_VERTICES : NV;
  localparam logic [CW-1:0] VLIM_C   = CW'(VLIM);
  localparam logic [AW-1:0] MAX_E_C  = AW'(MAX_EDGES);

  kmst_state_e   state_q, state_d;
  logic [CW-1:0] vc_q;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] k_q, k_d, pos_q, pos_d, hi_q, hi_d;
  logic [AW:0]   j_q, j_d;
  logic          building_q, building_d;
  kmst_edge_t    held_q, held_d, e_q, e_d, pend_q, pend_d;
  logic          pend_v_q, pend_v_d;
  logic [VW-1:0] ra_q, ra_d;
  logic [RANK_W-1:0] rka_q, rka_d;
  logic [CW-1:0] acc_q, acc_d;

  logic          str_q, str_d, ev_q, ev_d, lr_q, lr_d;
  kmst_edge_t    out_q, out_d;

  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  kmst_edge_t    wdata, rd_a, rd_b;
  uf_req_t       uf_req;
  uf_rsp_t       uf_rsp;

  logic [CW-1:0] n;
  logic          keep;
  logic          take_b;
  kmst_edge_t    child;
  logic [AW-1:0] cidx;

  kmst_edge_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  kmst_uf u_uf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (uf_req),
    .rsp_o  (uf_rsp)
  );

  // Effective vertex count and edge filter
  assign n    = (vc_q > VLIM_C) ? VLIM_C : vc_q;
  assign keep = (weight_i != '0) && (weight_i != NO_EDGE_W) &&
                ({1'b0, row_vertex_i} < n) && ({1'b0, col_vertex_i} < n) &&
                (cnt_q < MAX_E_C);

  // Pick the larger child
  assign take_b = (j_q < {1'b0, hi_q}) && (rd_a.w < rd_b.w);
  assign child  = take_b ? rd_b : rd_a;
  assign cidx   = take_b ? AW'(j_q + 1'b1) : j_q[AW-1:0];

  assign busy_o        = (state_q != ST_LOAD);
  assign res_strobe_o  = str_q;
  assign edge_from_o   = out_q.src;
  assign edge_to_o     = out_q.dst;
  assign edge_weight_o = out_q.w;
  assign edge_valid_o  = ev_q;
  assign last_result_o = lr_q;

  // Sequencer: load, heapsort, union-find scan
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    pos_d      = pos_q;
    hi_d       = hi_q;
    j_d        = j_q;
    building_d = building_q;
    held_d     = held_q;
    e_d        = e_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    ra_d       = ra_q;
    rka_d      = rka_q;
    acc_d      = acc_q;
    str_d      = 1'b0;
    ev_d       = ev_q;
    lr_d       = lr_q;
    out_d      = out_q;
    we         = 1'b0;
    waddr      = pos_q;
    wdata      = held_q;
    raddr_a    = j_q[AW-1:0];
    raddr_b    = j_q[AW-1:0];
    uf_req     = '0;
    case (state_q)
      ST_LOAD: begin
        waddr = cnt_q + 1'b1;
        wdata = '{src: row_vertex_i, dst: col_vertex_i, w: weight_i};
        if (start_i && keep) begin
          we    = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
        if (start_i && last_entry_i) begin
          state_d = ST_SORT_INIT;
        end
      end
      ST_SORT_INIT: begin
        k_d        = cnt_q >> 1;
        building_d = 1'b1;
        state_d    = ST_BUILD;
      end
      ST_BUILD: begin
        raddr_a = k_q;
        if (k_q == '0) begin
          k_d        = cnt_q;
          building_d = 1'b0;
          state_d    = ST_EXTRACT;
        end else begin
          state_d = ST_HELD;
        end
      end
      ST_HELD: begin
        held_d  = rd_a;
        pos_d   = k_q;
        j_d     = {k_q, 1'b0};
        hi_d    = cnt_q;
        state_d = ST_SIFT_RD;
      end
      ST_SIFT_RD: begin
        raddr_a = j_q[AW-1:0];
        raddr_b = (j_q < {1'b0, hi_q}) ? AW'(j_q + 1'b1) : j_q[AW-1:0];
        if (j_q <= {1'b0, hi_q}) begin
          state_d = ST_SIFT_CMP;
        end else begin
          we      = 1'b1;
          k_d     = k_q - 1'b1;
          state_d = building_q ? ST_BUILD : ST_EXTRACT;
        end
      end
      ST_SIFT_CMP: begin
        we = 1'b1;
        if (held_q.w < child.w) begin
          wdata   = child;
          pos_d   = cidx;
          j_d     = {cidx, 1'b0};
          state_d = ST_SIFT_RD;
        end else begin
          k_d     = k_q - 1'b1;
          state_d = building_q ? ST_BUILD : ST_EXTRACT;
        end
      end
      ST_EXTRACT: begin
        raddr_a = AW'(1);
        raddr_b = k_q;
        if (k_q < AW'(2)) begin
          j_d     = (AW+1)'(1);
          state_d = ST_SCAN;
        end else begin
          state_d = ST_SWAP;
        end
      end
      ST_SWAP: begin
        // Root goes to the tail; the tail entry sifts down from the root
        we      = 1'b1;
        waddr   = k_q;
        wdata   = rd_a;
        held_d  = rd_b;
        pos_d   = AW'(1);
        j_d     = (AW+1)'(2);
        hi_d    = k_q - 1'b1;
        state_d = ST_SIFT_RD;
      end
      ST_SCAN: begin
        raddr_a = j_q[AW-1:0];
        if (({1'b0, acc_q} + 1'b1 < {1'b0, n}) && (j_q <= {1'b0, cnt_q})) begin
          state_d = ST_SCAN_RD;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SCAN_RD: begin
        e_d            = rd_a;
        uf_req.find_go = 1'b1;
        uf_req.find_v  = rd_a.src;
        state_d        = ST_FIND_A;
      end
      ST_FIND_A: begin
        if (uf_rsp.done) begin
          ra_d           = uf_rsp.root;
          rka_d          = uf_rsp.rank;
          uf_req.find_go = 1'b1;
          uf_req.find_v  = e_q.dst;
          state_d        = ST_FIND_B;
        end
      end
      ST_FIND_B: begin
        if (uf_rsp.done) begin
          if (uf_rsp.root != ra_q) begin
            uf_req.join_go = 1'b1;
            uf_req.ja      = ra_q;
            uf_req.jb      = uf_rsp.root;
            uf_req.rka     = rka_q;
            uf_req.rkb     = uf_rsp.rank;
            acc_d          = acc_q + 1'b1;
            // Release the held item; the new one may be the last
            if (pend_v_q) begin
              str_d = 1'b1;
              out_d = pend_q;
              ev_d  = 1'b1;
              lr_d  = 1'b0;
            end
            pend_d   = e_q;
            pend_v_d = 1'b1;
          end
          j_d     = j_q + 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_FINISH: begin
        str_d        = 1'b1;
        ev_d         = pend_v_q;
        lr_d         = 1'b1;
        out_d        = pend_v_q ? pend_q : '0;
        cnt_d        = '0;
        acc_d        = '0;
        pend_v_d     = 1'b0;
        uf_req.clear = 1'b1;
        state_d      = ST_LOAD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      vc_q       <= VC_RESET;
      cnt_q      <= '0;
      acc_q      <= '0;
      pend_v_q   <= 1'b0;
      str_q      <= 1'b0;
      building_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      acc_q      <= acc_d;
      pend_v_q   <= pend_v_d;
      str_q      <= str_d;
      building_q <= building_d;
      if (cfg_we_i) begin
        vc_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    pos_q  <= pos_d;
    hi_q   <= hi_d;
    j_q    <= j_d;
    held_q <= held_d;
    e_q    <= e_d;
    pend_q <= pend_d;
    ra_q   <= ra_d;
    rka_q  <= rka_d;
    ev_q   <= ev_d;
    lr_q   <= lr_d;
    out_q  <= out_d;
  end

`ifndef SYNTH
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !edge_valid_o |-> last_result_o && edge_weight_o == '0)
    else $error("empty result not final");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && last_result_o |-> !busy_o)
    else $error("final result while still busy");

  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> acc_q < n || acc_q == '0)
    else $error("accepted count passed vertex count");
`endif

endmodule

[sim/kruskal_minimum_spanning_tree_tb.sv]
module kruskal_minimum_spanning_tree_tb;
  import kmst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WDOG_LIMIT = 60000;
  localparam int RES_MAX    = 15;

  typedef struct {
    logic [VW-1:0] src;
    logic [VW-1:0] dst;
    logic [WW-1:0] w;
    logic          valid;
    logic          last;
  } mst_edge_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [CW-1:0] cfg_wdata_i = '0;
  logic          start_i = 1'b0;
  logic          busy_o;
  logic [VW-1:0] row_vertex_i = '0;
  logic [VW-1:0] col_vertex_i = '0;
  logic [WW-1:0] weight_i = '0;
  logic          last_entry_i = 1'b0;
  logic          res_strobe_o;
  logic [VW-1:0] edge_from_o;
  logic [VW-1:0] edge_to_o;
  logic [WW-1:0] edge_weight_o;
  logic          edge_valid_o;
  logic          last_result_o;

  // Predictor state: edge list (1-based), forest and vertex count
  kmst_edge_t    edge_list [0:MAX_EDGES_DEF];
  int            edge_total;
  int            parent_of [0:NV-1];
  int            rank_of   [0:NV-1];
  int            vcount;
  mst_edge_t     tree_q[$];

  int items_sent;
  int results_seen;
  int graphs_done;
  int mismatches;
  int idle_pct;
  int wdog;

  kruskal_minimum_spanning_tree u_dut (.*);

  // Clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int vlimit();
    return (vcount > 16) ? 16 : vcount;
  endfunction

  function automatic void sift_down(int lo, int hi);
    int i;
    int j;
    kmst_edge_t held;
    i = lo;
    j = 2 * i;
    held = edge_list[i];
    while (j <= hi) begin
      if (j < hi && edge_list[j].w < edge_list[j+1].w) j++;
      if (held.w < edge_list[j].w) begin
        edge_list[i] = edge_list[j];
        i = j;
        j = 2 * i;
      end else begin
        break;
      end
    end
    edge_list[i] = held;
  endfunction

  function automatic int root_of(int x);
    for (int s = 0; s < NV; s++) begin
      if (parent_of[x] == x) break;
      x = parent_of[x];
    end
    return x;
  endfunction

  function automatic void forest_reset();
    for (int i = 0; i < NV; i++) begin
      parent_of[i] = i;
      rank_of[i] = 0;
    end
  endfunction

  // Store one entry; on the last entry sort, scan and queue tree edges
  function automatic void predict_tree(logic [VW-1:0] r, logic [VW-1:0] c,
                                       logic [WW-1:0] w, logic last);
    int n;
    int j;
    int a;
    int b;
    int got;
    kmst_edge_t t;
    mst_edge_t e;
    n = vlimit();
    if (w != '0 && w != NO_EDGE_W && r < n && c < n && edge_total < MAX_EDGES_DEF) begin
      edge_total++;
      edge_list[edge_total] = '{src: r, dst: c, w: w};
    end
    if (!last) return;
    for (int i = edge_total / 2; i >= 1; i--) sift_down(i, edge_total);
    for (int i = edge_total; i >= 2; i--) begin
      t = edge_list[1];
      edge_list[1] = edge_list[i];
      edge_list[i] = t;
      sift_down(1, i - 1);
    end
    forest_reset();
    got = 0;
    j = 1;
    while (got + 1 < n && j <= edge_total && got < RES_MAX) begin
      a = root_of(edge_list[j].src);
      b = root_of(edge_list[j].dst);
      if (a != b) begin
        e = '{src: edge_list[j].src, dst: edge_list[j].dst, w: edge_list[j].w,
              valid: 1'b1, last: 1'b0};
        tree_q.push_back(e);
        got++;
        if (rank_of[a] > rank_of[b]) begin
          parent_of[b] = a;
        end else begin
          parent_of[a] = b;
          if (rank_of[a] == rank_of[b] && rank_of[b] < 7) rank_of[b]++;
        end
      end
      j++;
    end
    if (got == 0) begin
      e = '{src: '0, dst: '0, w: '0, valid: 1'b0, last: 1'b1};
      tree_q.push_back(e);
    end else begin
      tree_q[tree_q.size()-1].last = 1'b1;
    end
    edge_total = 0;
    forest_reset();
    graphs_done++;
  endfunction

  // Check each strobed result against the oldest expected tree edge
  always @(posedge clk_i) begin
    mst_edge_t e;
    if (rst_ni && res_strobe_o) begin
      results_seen++;
      if (tree_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: from=%0d to=%0d w=%0d valid=%b last=%b",
                   edge_from_o, edge_to_o, edge_weight_o, edge_valid_o, last_result_o);
      end else begin
        e = tree_q.pop_front();
        if (edge_from_o !== e.src || edge_to_o !== e.dst || edge_weight_o !== e.w ||
            edge_valid_o !== e.valid || last_result_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp from=%0d to=%0d w=%0d valid=%b last=%b,",
                      " got %0d %0d %0d %b %b"},
                     e.src, e.dst, e.w, e.valid, e.last, edge_from_o, edge_to_o,
                     edge_weight_o, edge_valid_o, last_result_o);
        end
      end
    end
  end

  // Watchdog: count cycles with no item and no result
  always @(posedge clk_i) begin
    if (!rst_ni || res_strobe_o || (start_i && !busy_o)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("watchdog expired");
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_entry(logic [VW-1:0] r, logic [VW-1:0] c, logic [WW-1:0] w,
                            logic last);
    row_vertex_i <= r;
    col_vertex_i <= c;
    weight_i <= w;
    last_entry_i <= last;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    predict_tree(r, c, w, last);
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Hold off until all results are in and the block is idle
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (tree_q.size() != 0 || busy_o);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_vertices(logic [CW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vcount = v;
  endtask

  function automatic logic [WW-1:0] rand_weight();
    case ($urandom_range(9))
      0:       return '0;
      1:       return NO_EDGE_W;
      2, 3, 4: return WW'($urandom_range(1, 6));
      default: return WW'($urandom_range(0, 32767));
    endcase
  endfunction

  task automatic test_directed();
    // Default size 16: extremes, self loop, repeat, no-edge markers
    send_entry(4'd0, 4'd15, 15'd32766, 1'b0);
    send_entry(4'd15, 4'd0, 15'd1, 1'b0);
    send_entry(4'd15, 4'd15, 15'd1, 1'b0);
    send_entry(4'd0, 4'd15, 15'd1, 1'b0);
    send_entry(4'd3, 4'd4, 15'd0, 1'b0);
    send_entry(4'd3, 4'd4, NO_EDGE_W, 1'b0);
    send_entry(4'd3, 4'd4, 15'd5, 1'b1);
    drain();
    // Last entry without any edge yields the empty result
    send_entry(4'd1, 4'd2, 15'd0, 1'b1);
    drain();
    // Small graph with out-of-range vertices and ties
    set_vertices(5'd4);
    send_entry(4'd15, 4'd1, 15'd2, 1'b0);
    send_entry(4'd1, 4'd4, 15'd2, 1'b0);
    send_entry(4'd0, 4'd1, 15'd2, 1'b0);
    send_entry(4'd1, 4'd2, 15'd2, 1'b0);
    send_entry(4'd2, 4'd3, 15'd2, 1'b0);
    send_entry(4'd0, 4'd3, 15'd2, 1'b1);
    drain();
    // One vertex and no vertices: no tree edge can be accepted
    set_vertices(5'd1);
    send_entry(4'd0, 4'd0, 15'd7, 1'b1);
    drain();
    set_vertices(5'd0);
    send_entry(4'd0, 4'd0, 15'd7, 1'b1);
    drain();
    // Above sixteen behaves as sixteen
    set_vertices(5'd31);
    send_entry(4'd14, 4'd15, 15'd9, 1'b1);
    drain();
  endtask

  // Fill the edge store past its capacity
  task automatic test_store_full();
    set_vertices(5'd16);
    for (int i = 0; i < MAX_EDGES_DEF + 3; i++)
      send_entry(4'($urandom_range(15)), 4'($urandom_range(15)),
                 WW'($urandom_range(1, 32766)), i == MAX_EDGES_DEF + 2);
    drain();
  endtask

  task automatic test_random_graphs(int quota);
    int n;
    int stop;
    stop = items_sent + quota;
    while (items_sent < stop) begin
      set_vertices(CW'($urandom_range(0, 9) == 0 ? $urandom_range(0, 31)
                                                 : $urandom_range(2, 16)));
      n = vlimit();
      if (n >= 1 && n <= 6 && $urandom_range(1)) begin
        // Full matrix, row by row
        for (int r = 0; r < n; r++)
          for (int c = 0; c < n; c++)
            send_entry(VW'(r), VW'(c), rand_weight(), r == n - 1 && c == n - 1);
      end else begin
        // Sparse entries with some noise
        int k;
        k = $urandom_range(1, 24);
        for (int i = 0; i < k; i++)
          send_entry(VW'($urandom_range(3) == 0 ? $urandom_range(15)
                                                : $urandom_range(0, n > 0 ? n - 1 : 0)),
                     VW'($urandom_range(15) == 0 ? $urandom_range(15)
                                                : $urandom_range(0, n > 0 ? n - 1 : 0)),
                     rand_weight(), i == k - 1);
      end
      drain();
    end
  endtask

  initial begin
    vcount = VC_RESET;
    edge_total = 0;
    items_sent = 0;
    results_seen = 0;
    graphs_done = 0;
    mismatches = 0;
    idle_pct = 0;
    wdog = 0;
    forest_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_store_full();
    idle_pct = 0;
    test_random_graphs(10);
    idle_pct = 51;
    test_random_graphs(10);
    idle_pct = 30;
    test_random_graphs(10);
    idle_pct = 0;
    set_vertices(5'd16);
    drain();

    if (tree_q.size() != 0) mismatches++;
    $display("covered %0d entries over %0d graphs, %0d tree results checked",
             items_sent, graphs_done, results_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
